// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL module i2c_bus_sniffer.
// Users must provide clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check a property on every rising clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/i2cbs_pkg.sv =====
// Types and constants of the I2C bus sniffer.
// No dependencies.
package i2cbs_pkg;

  localparam int FRAME_SLOTS     = 32;
  localparam int BYTES_PER_FRAME = 32;

  typedef enum logic [1:0] {
    MODE_SDA  = 2'd0,
    MODE_SCL  = 2'd1,
    MODE_READ = 2'd2,
    MODE_IDLE = 2'd3
  } mode_t;

  localparam logic [3:0] BIT_ACK = 4'd8;

  typedef struct packed {
    mode_t      mode;
    logic       scl_level;
    logic       sda_level;
    logic [4:0] frame_select;
    logic [4:0] byte_select;
  } in_t;

  typedef struct packed {
    logic       bus_started;
    logic       stop_seen;
    logic [4:0] current_frame;
    logic [5:0] current_byte_count;
    logic       byte_done;
    logic [7:0] data_byte;
    logic       data_ack;
    logic [5:0] read_count;
  } out_t;

endpackage

// ===== rtl/i2c_bus_sniffer.sv =====
// Passive I2C bus sniffer: frame tracking, byte capture and stored-byte readback.
// Depends on i2cbs_pkg and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid, in_stall, in_data): one bus event per transaction,
//   either an SDA edge, a rising SCL edge, a read of a stored byte or a forced
//   return to idle. Result channel (out_valid, out_stall, out_data): exactly one
//   result transaction per event, in event order.
//   Pipeline: an accepted event passes the read stage (synchronous byte/ack
//   store and frame count memory read), then the output register to out_valid.
//   Throughput: one event per cycle unless in_stall holds it; bus state, bit
//   and byte counters of the current frame live in registers, so consecutive
//   events never wait on the memories. Each memory has one write and one read
//   port and a write and a read never fall on the same edge for the same event.
//   Stall: while out_stall holds a waiting result, one more event is still
//   taken into the read stage; after that in_stall rises until the output
//   drains.
//   Reset: the bus goes idle, the frame pointer and counters go to zero. The
//   memories need no clearing pass: a stored byte or frame count is only
//   returned once written after the last reset or store overflow.
`include "assert_macros.svh"

module i2c_bus_sniffer
  import i2cbs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int FW    = $clog2(FRAME_SLOTS);
  localparam int CW    = $clog2(BYTES_PER_FRAME + 1);
  localparam int DEPTH = FRAME_SLOTS * BYTES_PER_FRAME;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [FW-1:0] LAST_FRAME = FW'(FRAME_SLOTS - 1);

  // bus state of the current frame
  logic          started_r, started_nxt;
  logic          first_r, first_nxt;
  logic [FW-1:0] fp_r, fp_nxt;
  logic [3:0]    bit_cnt_r, bit_cnt_nxt;
  logic [CW-1:0] cur_cnt_r, cur_cnt_nxt;
  logic [7:0]    shift_r, shift_nxt;

  logic stop_s0, done_s0, st_we, cnt_we;

  // memories
  logic [8:0]    store_mem [DEPTH];
  logic [CW-1:0] cnt_mem [FRAME_SLOTS];
  logic [8:0]    st_q;
  logic [CW-1:0] cnt_q;

  logic [AW-1:0] wr_addr, rd_addr;
  logic [FW-1:0] fsel_idx;
  logic          fsel_ok, bsel_ok;

  // read stage
  logic          s1_vld_r;
  logic          s1_started_r, s1_stop_r, s1_done_r;
  logic [FW-1:0] s1_fp_r;
  logic [CW-1:0] s1_cnt_r;
  logic [7:0]    s1_byte_r;
  logic          s1_ack_r;
  logic          s1_rd_mem_r, s1_rd_cur_r, s1_bsel_ok_r;
  logic [4:0]    s1_bsel_r;

  // output stage
  logic out_vld_r;
  out_t out_r, out_nxt;

  logic s1_adv, acc;
  logic [CW-1:0] rd_cnt;
  logic          rd_hit;

  assign s1_adv   = !out_vld_r || !out_stall;
  assign in_stall = s1_vld_r && !s1_adv;
  assign acc      = in_valid && !in_stall;

  always_comb begin
    started_nxt = started_r;
    first_nxt   = first_r;
    fp_nxt      = fp_r;
    bit_cnt_nxt = bit_cnt_r;
    cur_cnt_nxt = cur_cnt_r;
    shift_nxt   = shift_r;
    stop_s0     = 1'b0;
    done_s0     = 1'b0;
    st_we       = 1'b0;
    cnt_we      = 1'b0;
    unique case (in_data.mode)
      MODE_SDA: begin
        if (in_data.scl_level) begin
          if (started_r) begin
            if (in_data.sda_level) begin
              started_nxt = 1'b0;
              stop_s0     = 1'b1;
            end
          end else if (!in_data.sda_level) begin
            started_nxt = 1'b1;
            if (first_r) begin
              first_nxt = 1'b0;
            end else if (fp_r == LAST_FRAME) begin
              started_nxt = 1'b0;
              first_nxt   = 1'b1;
              fp_nxt      = '0;
              bit_cnt_nxt = '0;
              cur_cnt_nxt = '0;
            end else begin
              cnt_we      = 1'b1;
              fp_nxt      = fp_r + FW'(1);
              bit_cnt_nxt = '0;
              cur_cnt_nxt = '0;
            end
          end
        end
      end
      MODE_SCL: begin
        if (started_r && (32'(cur_cnt_r) < BYTES_PER_FRAME)) begin
          if (bit_cnt_r < BIT_ACK) begin
            shift_nxt   = {shift_r[6:0], in_data.sda_level};
            bit_cnt_nxt = bit_cnt_r + 4'd1;
          end else begin
            st_we       = 1'b1;
            done_s0     = 1'b1;
            bit_cnt_nxt = '0;
            cur_cnt_nxt = cur_cnt_r + CW'(1);
          end
        end
      end
      MODE_READ: begin
      end
      MODE_IDLE: begin
        started_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign fsel_idx = FW'(in_data.frame_select);
  assign fsel_ok  = 32'(in_data.frame_select) < FRAME_SLOTS;
  assign bsel_ok  = 32'(in_data.byte_select) < BYTES_PER_FRAME;
  assign wr_addr  = AW'(32'(fp_r) * BYTES_PER_FRAME + 32'(cur_cnt_r));
  assign rd_addr  = AW'(32'(fsel_idx) * BYTES_PER_FRAME + 32'(in_data.byte_select));

  always_ff @(posedge clk) begin
    if (acc && st_we) begin
      store_mem[wr_addr] <= {shift_r, !in_data.sda_level};
    end
    if (acc && (in_data.mode == MODE_READ)) begin
      st_q <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (acc && cnt_we) begin
      cnt_mem[fp_r] <= cur_cnt_r;
    end
    if (acc && (in_data.mode == MODE_READ)) begin
      cnt_q <= cnt_mem[fsel_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      first_r   <= 1'b1;
      fp_r      <= '0;
      bit_cnt_r <= '0;
      cur_cnt_r <= '0;
    end else if (acc) begin
      started_r <= started_nxt;
      first_r   <= first_nxt;
      fp_r      <= fp_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      cur_cnt_r <= cur_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      shift_r <= shift_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_started_r <= started_nxt;
      s1_stop_r    <= stop_s0;
      s1_done_r    <= done_s0;
      s1_fp_r      <= fp_nxt;
      s1_cnt_r     <= cur_cnt_nxt;
      s1_byte_r    <= shift_r;
      s1_ack_r     <= !in_data.sda_level;
      s1_rd_mem_r  <= (in_data.mode == MODE_READ) && fsel_ok && (fsel_idx < fp_r);
      s1_rd_cur_r  <= (in_data.mode == MODE_READ) && fsel_ok && (fsel_idx == fp_r);
      s1_bsel_r    <= in_data.byte_select;
      s1_bsel_ok_r <= bsel_ok;
    end
  end

  always_comb begin
    priority if (s1_rd_mem_r) begin
      rd_cnt = cnt_q;
    end else if (s1_rd_cur_r) begin
      rd_cnt = s1_cnt_r;
    end else begin
      rd_cnt = '0;
    end
    rd_hit = s1_bsel_ok_r && (32'(s1_bsel_r) < 32'(rd_cnt));

    out_nxt.bus_started        = s1_started_r;
    out_nxt.stop_seen          = s1_stop_r;
    out_nxt.current_frame      = 5'(s1_fp_r);
    out_nxt.current_byte_count = 6'(s1_cnt_r);
    out_nxt.byte_done          = s1_done_r;
    out_nxt.read_count         = 6'(rd_cnt);
    priority if (s1_done_r) begin
      out_nxt.data_byte = s1_byte_r;
      out_nxt.data_ack  = s1_ack_r;
    end else if (rd_hit) begin
      out_nxt.data_byte = st_q[8:1];
      out_nxt.data_ack  = st_q[0];
    end else begin
      out_nxt.data_byte = '0;
      out_nxt.data_ack  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_vld_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  `ASSERT_CLK(a_cnt_range, 32'(cur_cnt_r) <= BYTES_PER_FRAME, "byte count beyond frame capacity")
  `ASSERT_CLK(a_new_frame, acc && cnt_we |=> cur_cnt_r == '0 && bit_cnt_r == '0, "stale frame")
  `ASSERT_CLK(a_s1_hold, s1_vld_r && !s1_adv |=> s1_vld_r && $stable(s1_fp_r), "held stage lost")
  `ASSERT_CLK(a_one_write, !(st_we && cnt_we), "store and count written by one event")

endmodule

// ===== test/i2c_bus_sniffer_tb.sv =====
// Self-checking testbench for the I2C bus sniffer: start/stop tracking, byte capture,
// frame overflow and stored-byte readback, with random idling on both channels and then at full rate.
// Depends on i2cbs_pkg and the i2c_bus_sniffer RTL.
module i2c_bus_sniffer_tb;
  import i2cbs_pkg::*;

  localparam int FRAMES      = 32;
  localparam int FRAME_BYTES = 32;
  localparam int IN_W        = $bits(in_t);

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  i2c_bus_sniffer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // sniffer state as the bus should leave it
  logic       bus_open;
  logic       first_start;
  logic [4:0] frame_ptr;
  logic [7:0] byte_mem [0:FRAMES*FRAME_BYTES-1];
  logic       ack_mem  [0:FRAMES*FRAME_BYTES-1];
  logic [3:0] bit_cnt  [0:FRAMES-1];
  logic [5:0] byte_cnt [0:FRAMES-1];

  out_t expected_results [$];
  int   events_sent    = 0;
  int   results_seen   = 0;
  int   bytes_captured = 0;
  int   store_wraps    = 0;
  int   mismatches     = 0;
  int   gap_pct        = 0;
  int   stall_pct      = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("i2c_bus_sniffer_tb failed");
    $finish;
  end

  function automatic void wipe_capture();
    for (int i = 0; i < FRAMES * FRAME_BYTES; i++) begin
      byte_mem[i] = 8'd0;
      ack_mem[i]  = 1'b0;
    end
    for (int i = 0; i < FRAMES; i++) begin
      bit_cnt[i]  = 4'd0;
      byte_cnt[i] = 6'd0;
    end
    frame_ptr   = 5'd0;
    bus_open    = 1'b0;
    first_start = 1'b1;
  endfunction

  function automatic out_t sniff_event(in_t ev);
    out_t       res;
    int         idx;
    logic [4:0] f;
    res = '0;
    f   = frame_ptr;
    case (ev.mode)
      MODE_SDA: begin
        if (ev.scl_level) begin
          if (bus_open) begin
            if (ev.sda_level) begin
              bus_open      = 1'b0;
              res.stop_seen = 1'b1;
            end
          end else if (!ev.sda_level) begin
            bus_open = 1'b1;
            if (first_start) begin
              first_start = 1'b0;
            end else if (frame_ptr == FRAMES - 1) begin
              wipe_capture();
              store_wraps++;
            end else begin
              frame_ptr++;
            end
          end
        end
      end
      MODE_SCL: begin
        if (bus_open && byte_cnt[f] < FRAME_BYTES) begin
          idx = f * FRAME_BYTES + byte_cnt[f];
          if (bit_cnt[f] < BIT_ACK) begin
            byte_mem[idx] = {byte_mem[idx][6:0], ev.sda_level};
            bit_cnt[f]++;
          end else begin
            ack_mem[idx]  = !ev.sda_level;
            byte_cnt[f]++;
            bit_cnt[f]    = 4'd0;
            res.byte_done = 1'b1;
            res.data_byte = byte_mem[idx];
            res.data_ack  = ack_mem[idx];
            bytes_captured++;
          end
        end
      end
      MODE_READ: begin
        res.read_count = byte_cnt[ev.frame_select];
        if (ev.byte_select < byte_cnt[ev.frame_select]) begin
          idx           = ev.frame_select * FRAME_BYTES + ev.byte_select;
          res.data_byte = byte_mem[idx];
          res.data_ack  = ack_mem[idx];
        end
      end
      default: bus_open = 1'b0;
    endcase
    res.bus_started        = bus_open;
    res.current_frame      = frame_ptr;
    res.current_byte_count = byte_cnt[frame_ptr];
    return res;
  endfunction

  function automatic in_t make_event(mode_t mode, logic scl, logic sda);
    in_t ev;
    ev.mode         = mode;
    ev.scl_level    = scl;
    ev.sda_level    = sda;
    ev.frame_select = 5'($urandom);
    ev.byte_select  = 5'($urandom);
    return ev;
  endfunction

  function automatic in_t make_read(int frame, int position);
    in_t ev;
    ev              = make_event(MODE_READ, 1'($urandom), 1'($urandom));
    ev.frame_select = 5'(frame);
    ev.byte_select  = 5'(position);
    return ev;
  endfunction

  task automatic send_event(in_t ev);
    if (events_sent < 350) begin
      gap_pct   = 27;
      stall_pct = 76;
    end else if (events_sent < 700) begin
      gap_pct   = 76;
      stall_pct = 27;
    end else begin
      gap_pct   = 0;
      stall_pct = 0;
    end
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(sniff_event(ev));
    events_sent++;
    @(negedge clk);
  endtask

  task automatic send_bits(int count);
    repeat (count) send_event(make_event(MODE_SCL, 1'b1, 1'($urandom)));
  endtask

  task automatic send_byte(logic [7:0] value, logic acked);
    for (int i = 7; i >= 0; i--) send_event(make_event(MODE_SCL, 1'b1, value[i]));
    send_event(make_event(MODE_SCL, 1'b1, !acked));
  endtask

  task automatic send_read();
    int frame;
    int position;
    frame    = $urandom_range(1) ? $urandom_range(frame_ptr) : $urandom_range(FRAMES - 1);
    position = $urandom_range(1) ? $urandom_range(byte_cnt[frame]) : $urandom_range(31);
    send_event(make_read(frame, position > 31 ? 31 : position));
  endtask

  task automatic test_directed();
    send_event(make_event(MODE_SDA, 1'b0, 1'b0));
    send_event(make_event(MODE_SDA, 1'b1, 1'b1));
    send_event(make_event(MODE_SCL, 1'b1, 1'b1));
    send_event(make_read(31, 31));
    send_event(make_event(MODE_SDA, 1'b1, 1'b0));
    send_event(make_event(MODE_SDA, 1'b1, 1'b0));
    send_byte(8'hA5, 1'b1);
    send_event(make_event(MODE_SDA, 1'b1, 1'b1));
    send_event(make_read(0, 0));
    send_event(make_read(0, 1));
    send_event(make_event(MODE_SDA, 1'b1, 1'b0));
    send_bits(3);
    send_event(make_event(MODE_IDLE, 1'b0, 1'b1));
    send_event(make_event(MODE_SCL, 1'b1, 1'b0));
    send_event(make_read(1, 0));
  endtask

  task automatic test_frame_full();
    logic [7:0] value;
    send_event(make_event(MODE_SDA, 1'b1, 1'b0));
    for (int i = 0; i <= FRAME_BYTES; i++) begin
      value = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom);
      send_byte(value, 1'($urandom));
    end
    send_bits(3);
    for (int i = 0; i < FRAME_BYTES; i++) send_event(make_read(frame_ptr, i));
    send_event(make_event(MODE_SDA, 1'b1, 1'b1));
  endtask

  task automatic test_store_overflow();
    int wraps_at_entry;
    wraps_at_entry = store_wraps;
    while (store_wraps == wraps_at_entry) begin
      send_event(make_event(MODE_SDA, 1'b1, 1'b0));
      if ($urandom_range(3) == 0) send_byte(8'($urandom), 1'($urandom));
      if ($urandom_range(4) == 0) send_bits($urandom_range(1, 7));
      case ($urandom_range(9))
        0, 1: send_event(make_event(MODE_IDLE, 1'($urandom), 1'($urandom)));
        2: begin
          send_event(make_event(MODE_SDA, 1'b1, 1'b0));
          send_event(make_event(MODE_SDA, 1'b1, 1'b1));
        end
        default: send_event(make_event(MODE_SDA, 1'b1, 1'b1));
      endcase
      if ($urandom_range(3) == 0) send_read();
    end
    send_event(make_read(2, 0));
    send_event(make_read(31, 31));
    send_event(make_event(MODE_SDA, 1'b1, 1'b0));
    send_byte(8'($urandom), 1'($urandom));
    send_event(make_event(MODE_SDA, 1'b1, 1'b1));
    send_event(make_read(0, 0));
  endtask

  task automatic test_random_traffic();
    int pick;
    while (events_sent < 1050) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_event(make_event(MODE_SDA, 1'b1, 1'b0));
        repeat ($urandom_range(4)) begin
          send_byte(8'($urandom), 1'($urandom));
          if ($urandom_range(9) == 0) send_event(make_event(MODE_SDA, 1'b1, 1'b0));
          if ($urandom_range(9) == 0) send_event(make_event(MODE_SDA, 1'b0, 1'($urandom)));
        end
        if ($urandom_range(9) == 0) send_bits($urandom_range(1, 8));
        if ($urandom_range(4) == 0) begin
          send_event(make_event(MODE_IDLE, 1'($urandom), 1'($urandom)));
        end else begin
          send_event(make_event(MODE_SDA, 1'b1, 1'b1));
        end
      end else if (pick < 80) begin
        send_read();
      end else begin
        send_event(in_t'(IN_W'($urandom)));
      end
    end
  endtask

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 200)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
      end else begin
        want = expected_results.pop_front();
        check_field("bus_started", want.bus_started, out_data.bus_started);
        check_field("stop_seen", want.stop_seen, out_data.stop_seen);
        check_field("current_frame", want.current_frame, out_data.current_frame);
        check_field("current_byte_count", want.current_byte_count,
                    out_data.current_byte_count);
        check_field("byte_done", want.byte_done, out_data.byte_done);
        check_field("data_byte", want.data_byte, out_data.data_byte);
        check_field("data_ack", want.data_ack, out_data.data_ack);
        check_field("read_count", want.read_count, out_data.read_count);
        results_seen++;
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    wipe_capture();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_frame_full();
    test_store_overflow();
    test_random_traffic();

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d bus events and %0d results: %0d bytes captured, %0d store wraps,",
             events_sent, results_seen, bytes_captured, store_wraps);
    $display("with idling on either side in turn and then at full rate.");
    if (mismatches == 0) begin
      $display("i2c_bus_sniffer_tb passed");
    end else begin
      $display("i2c_bus_sniffer_tb failed");
    end
    $finish;
  end

endmodule
